// ===== sv/gvt_pkg.sv =====
// Shared widths, types and the arctangent table for the tilt unit.
`timescale 1ns / 1ps
`default_nettype none
package gvt_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CFG_W      = 12;
    localparam int MIN_SQ_W   = 2 * CFG_W;
    localparam int FRAC_SH    = 32 - SAMPLE_W;
    localparam int SQ_W       = 2 * SAMPLE_W;
    localparam int SUM2_W     = 2 * SAMPLE_W;
    localparam int TOT_W      = 2 * SAMPLE_W + 1;
    localparam int RAD_W      = SUM2_W + 2 * FRAC_SH;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int XY_SH      = 16;
    localparam int C_W        = ROOT_W + XY_SH + 3;
    localparam int CORDIC_N   = 22;
    localparam int ACC_W      = 24;
    localparam int ANG_W      = 15;
    localparam int ANGLE_LIM  = 11520;
    localparam int MIN_NORM_RST = 10;

    localparam logic signed [ACC_W-1:0] ATAN_TAB [CORDIC_N] = '{
        24'sd1474560, 24'sd870484, 24'sd459940, 24'sd233473, 24'sd117189,
        24'sd58652, 24'sd29333, 24'sd14667, 24'sd7334, 24'sd3667,
        24'sd1833, 24'sd917, 24'sd458, 24'sd229, 24'sd115, 24'sd57,
        24'sd29, 24'sd14, 24'sd7, 24'sd4, 24'sd2, 24'sd1
    };

    typedef struct packed {
        logic                       ok;
        logic signed [SAMPLE_W-1:0] num;
    } lane_t;

endpackage
`default_nettype wire

// ===== sv/gravity_vector_to_tilt_unit.sv =====
// Top level of the gravity-vector tilt unit.
`timescale 1ns / 1ps
`default_nettype none
// Takes one gravity vector per transfer and returns roll and pitch in 1/128
// degree, plus a flag that is low (angles zero) when the vector is shorter
// than min_norm. A vector can be taken every clock cycle unless the result
// transfer stalls, which holds the whole pipeline. Results pass through the
// 32-stage square root and 22-stage CORDIC. min_norm resets to 10 and must be
// written through cfg_we/cfg_wdata only while idle; the block does not check.
module gravity_vector_to_tilt_unit
    import gvt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [11:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // grav_x, grav_y, grav_z
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // roll_angle, pitch_angle, zero pad
    output logic             m_tuser    // angles_valid
);

    logic                  adv;
    logic [MIN_SQ_W-1:0]   min_sq_reg;
    logic                  f_valid, r_sv, p_sv, r_cv, p_cv;
    logic [SUM2_W-1:0]     sum_r, sum_p;
    lane_t                 lane_r, lane_p, lr_s, lp_s;
    logic [ROOT_W-1:0]     root_r, root_p;
    logic signed [ANG_W-1:0] roll, pitch;
    logic                  ok_reg [0:CORDIC_N+1];

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            min_sq_reg <= MIN_SQ_W'(MIN_NORM_RST * MIN_NORM_RST);
        else if (cfg_we)
            min_sq_reg <= MIN_SQ_W'(cfg_wdata * cfg_wdata);
    end

    gvt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (s_tvalid),
        .gx         ($signed(s_tdata[15:0])),
        .gy         ($signed(s_tdata[31:16])),
        .gz         ($signed(s_tdata[47:32])),
        .min_sq     (min_sq_reg),
        .out_valid  (f_valid),
        .sum_roll   (sum_r),
        .sum_pitch  (sum_p),
        .lane_roll  (lane_r),
        .lane_pitch (lane_p)
    );

    gvt_sqrt u_sqrt_roll (
        .clk (clk), .rst_n (rst_n), .en (adv), .in_valid (f_valid),
        .rad (sum_r), .in_lane (lane_r),
        .out_valid (r_sv), .root (root_r), .out_lane (lr_s)
    );

    gvt_sqrt u_sqrt_pitch (
        .clk (clk), .rst_n (rst_n), .en (adv), .in_valid (f_valid),
        .rad (sum_p), .in_lane (lane_p),
        .out_valid (p_sv), .root (root_p), .out_lane (lp_s)
    );

    gvt_cordic u_cordic_roll (
        .clk (clk), .rst_n (rst_n), .en (adv), .in_valid (r_sv),
        .root (root_r), .in_lane (lr_s),
        .out_valid (r_cv), .angle (roll)
    );

    gvt_cordic u_cordic_pitch (
        .clk (clk), .rst_n (rst_n), .en (adv), .in_valid (p_sv),
        .root (root_p), .in_lane (lp_s),
        .out_valid (p_cv), .angle (pitch)
    );

    // norm flag travels alongside the CORDIC
    always_ff @(posedge clk)
    begin
        if (adv)
            ok_reg[0] <= lr_s.ok;
    end

    for (genvar j = 0; j <= CORDIC_N; j++)
    begin : g_ok
        always_ff @(posedge clk)
        begin
            if (adv)
                ok_reg[j+1] <= ok_reg[j];
        end
    end

    assign m_tvalid = r_cv && p_cv;
    assign m_tdata  = {2'b00, pitch, roll};
    assign m_tuser  = ok_reg[CORDIC_N+1];

endmodule
`default_nettype wire

// ===== sv/gvt_front.sv =====
// Squares, pair sums and minimum-norm test.
`timescale 1ns / 1ps
`default_nettype none
module gvt_front
    import gvt_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       in_valid,
    input  wire logic signed [SAMPLE_W-1:0] gx,
    input  wire logic signed [SAMPLE_W-1:0] gy,
    input  wire logic signed [SAMPLE_W-1:0] gz,
    input  wire logic [MIN_SQ_W-1:0]        min_sq,
    output logic                            out_valid,
    output logic [SUM2_W-1:0]               sum_roll,
    output logic [SUM2_W-1:0]               sum_pitch,
    output lane_t                           lane_roll,
    output lane_t                           lane_pitch
);

    logic                       v1_reg, v2_reg;
    logic [SQ_W-1:0]            xx_reg, yy_reg, zz_reg;
    logic [SQ_W-1:0]            xx_next, yy_next, zz_next;
    logic signed [SAMPLE_W-1:0] x1_reg, y1_reg;
    logic [SUM2_W-1:0]          sr_reg, sp_reg;
    lane_t                      lr_reg, lp_reg;
    logic [TOT_W-1:0]           total;
    logic                       ok;

    assign xx_next = SQ_W'(gx * gx);
    assign yy_next = SQ_W'(gy * gy);
    assign zz_next = SQ_W'(gz * gz);
    assign total   = TOT_W'(xx_reg) + TOT_W'(yy_reg) + TOT_W'(zz_reg);
    assign ok      = total >= TOT_W'(min_sq);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg <= xx_next;
            yy_reg <= yy_next;
            zz_reg <= zz_next;
            x1_reg <= gx;
            y1_reg <= gy;
            sr_reg <= SUM2_W'(yy_reg) + SUM2_W'(zz_reg);
            sp_reg <= SUM2_W'(xx_reg) + SUM2_W'(zz_reg);
            lr_reg <= '{ok: ok, num: x1_reg};
            lp_reg <= '{ok: ok, num: y1_reg};
        end
    end

    assign out_valid  = v2_reg;
    assign sum_roll   = sr_reg;
    assign sum_pitch  = sp_reg;
    assign lane_roll  = lr_reg;
    assign lane_pitch = lp_reg;

endmodule
`default_nettype wire

// ===== sv/gvt_sqrt.sv =====
// Pipelined restoring square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module gvt_sqrt
    import gvt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [SUM2_W-1:0] rad,
    input  wire lane_t             in_lane,
    output logic                   out_valid,
    output logic [ROOT_W-1:0]      root,
    output lane_t                  out_lane
);

    logic              vld_reg  [0:ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [0:ROOT_W];
    logic [REM_W-1:0]  rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W];
    lane_t             lane_reg [0:ROOT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg[0]  <= {rad, {(2 * FRAC_SH){1'b0}}};
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            lane_reg[0] <= in_lane;
        end
    end

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_step
        logic [REM_W+1:0]  cand;
        logic [REM_W+1:0]  trial;
        logic              ge;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        assign cand      = {rem_reg[k], rad_reg[k][RAD_W-1 -: 2]};
        assign trial     = (REM_W + 2)'({root_reg[k], 2'b01});
        assign ge        = cand >= trial;
        assign rem_next  = ge ? REM_W'(cand - trial) : cand[REM_W-1:0];
        assign root_next = {root_reg[k][ROOT_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k+1] <= 1'b0;
            else if (en)
                vld_reg[k+1] <= vld_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k+1]  <= rad_reg[k] << 2;
                rem_reg[k+1]  <= rem_next;
                root_reg[k+1] <= root_next;
                lane_reg[k+1] <= lane_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W];
    assign root      = root_reg[ROOT_W];
    assign out_lane  = lane_reg[ROOT_W];

endmodule
`default_nettype wire

// ===== sv/gvt_cordic.sv =====
// Pipelined vectoring CORDIC with rounding and saturation to 1/128 degree.
`timescale 1ns / 1ps
`default_nettype none
module gvt_cordic
    import gvt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [ROOT_W-1:0] root,
    input  wire lane_t             in_lane,
    output logic                   out_valid,
    output logic signed [ANG_W-1:0] angle
);

    localparam int RND_W = ACC_W - 8;

    logic                    vld_reg  [0:CORDIC_N];
    logic signed [C_W-1:0]   x_reg    [0:CORDIC_N];
    logic signed [C_W-1:0]   y_reg    [0:CORDIC_N];
    logic signed [ACC_W-1:0] acc_reg  [0:CORDIC_N];
    logic                    keep_reg [0:CORDIC_N];
    logic                    ov_reg;
    logic signed [ANG_W-1:0] ang_reg;

    logic signed [C_W-1:0]   x_init, y_init;
    logic signed [ACC_W-1:0] acc_rnd;
    logic signed [RND_W-1:0] rnd;
    logic signed [ANG_W-1:0] sat;

    assign x_init = $signed(C_W'(root) << XY_SH);
    assign y_init = $signed({{(C_W - SAMPLE_W){in_lane.num[SAMPLE_W-1]}}, in_lane.num})
                    <<< (FRAC_SH + XY_SH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_init;
            y_reg[0]    <= y_init;
            acc_reg[0]  <= '0;
            keep_reg[0] <= in_lane.ok && (in_lane.num != '0);
        end
    end

    for (genvar i = 0; i < CORDIC_N; i++)
    begin : g_iter
        logic signed [C_W-1:0] dx, dy;
        logic                  pos;

        assign dx  = y_reg[i] >>> i;
        assign dy  = x_reg[i] >>> i;
        assign pos = y_reg[i] > 0;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else if (en)
                vld_reg[i+1] <= vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= pos ? x_reg[i] + dx : x_reg[i] - dx;
                y_reg[i+1]    <= pos ? y_reg[i] - dy : y_reg[i] + dy;
                acc_reg[i+1]  <= pos ? acc_reg[i] + ATAN_TAB[i] : acc_reg[i] - ATAN_TAB[i];
                keep_reg[i+1] <= keep_reg[i];
            end
        end
    end

    assign acc_rnd = acc_reg[CORDIC_N] + ACC_W'(128);
    assign rnd     = RND_W'(acc_rnd >>> 8);

    always_comb
    begin
        if (rnd > RND_W'(ANGLE_LIM))
            sat = ANG_W'(ANGLE_LIM);
        else if (rnd < -RND_W'(ANGLE_LIM))
            sat = -ANG_W'(ANGLE_LIM);
        else
            sat = rnd[ANG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (en)
            ov_reg <= vld_reg[CORDIC_N];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            ang_reg <= keep_reg[CORDIC_N] ? sat : '0;
    end

    assign out_valid = ov_reg;
    assign angle     = ang_reg;

endmodule
`default_nettype wire

// ===== sv/gvt_checker.sv =====
// Port-level checks for the tilt unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module gvt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed during stall");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == 32'd0)
        else $error("short vector gave nonzero angles");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[14:0]) <= 15'sd11520)
                  && ($signed(m_tdata[14:0]) >= -15'sd11520)
                  && ($signed(m_tdata[29:15]) <= 15'sd11520)
                  && ($signed(m_tdata[29:15]) >= -15'sd11520))
        else $error("angle beyond ninety degrees");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:30] == 2'b00)
        else $error("padding bits set");

endmodule

bind gravity_vector_to_tilt_unit gvt_checker u_gvt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ===== tb/sv/gravity_vector_to_tilt_unit_tb.sv =====
// Testbench for the gravity-vector tilt unit: directed table, random vectors, scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module gravity_vector_to_tilt_unit_tb;
    import gvt_pkg::*;

    typedef struct packed {
        logic signed [ANG_W-1:0] roll;
        logic signed [ANG_W-1:0] pitch;
        logic                    valid;
    } tilt_t;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        bit                 known;
        tilt_t              want;
    } vec_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [11:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    logic [11:0] min_norm_q = 12'(MIN_NORM_RST);
    tilt_t       tilt_q[$];
    int          n_fail = 0;
    int          n_vec = 0;
    int          n_valid = 0;
    int          n_invalid = 0;
    longint      cycle = 0;
    bit          stall_mode = 1'b0;

    gravity_vector_to_tilt_unit i_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > 64'd600000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic longint floor_shr(longint v, int k);
        if (v >= 0)
            return v >>> k;
        return -((-(v + 1)) >>> k) - 1;
    endfunction

    function automatic longint isqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic logic signed [ANG_W-1:0] tilt_of(longint num, longint unsigned sq);
        longint a, b, acc, da, db;
        acc = 0;
        if (num == 0)
            return '0;
        a = isqrt(sq << (2 * FRAC_SH)) * 65536;
        b = num * (64'sd1 <<< (FRAC_SH + 16));
        for (int i = 0; i < CORDIC_N; i++)
        begin
            da = floor_shr(b, i);
            db = floor_shr(a, i);
            if (b > 0)
            begin
                a += da;
                b -= db;
                acc += longint'(ATAN_TAB[i]);
            end
            else
            begin
                a -= da;
                b += db;
                acc -= longint'(ATAN_TAB[i]);
            end
        end
        acc = floor_shr(acc + 128, 8);
        if (acc > ANGLE_LIM)
            acc = ANGLE_LIM;
        if (acc < -ANGLE_LIM)
            acc = -ANGLE_LIM;
        return ANG_W'(acc);
    endfunction

    function automatic tilt_t predict_tilt(logic signed [15:0] x, logic signed [15:0] y,
                                           logic signed [15:0] z);
        tilt_t t;
        longint unsigned xx, yy, zz;
        xx = longint'(x) * longint'(x);
        yy = longint'(y) * longint'(y);
        zz = longint'(z) * longint'(z);
        t = '0;
        if (xx + yy + zz < longint'(min_norm_q) * longint'(min_norm_q))
            return t;
        t.roll = tilt_of(x, yy + zz);
        t.pitch = tilt_of(y, xx + zz);
        t.valid = 1'b1;
        return t;
    endfunction

    task automatic send_vector(vec_row_t r);
        tilt_t t;
        t = predict_tilt(r.x, r.y, r.z);
        if (r.known && t != r.want)
        begin
            $display("%0t table row disagrees with predictor: row %h pred %h", $time, r.want, t);
            n_fail++;
        end
        s_tvalid <= 1'b1;
        s_tdata <= {r.z, r.y, r.x};
        do
            @(posedge clk);
        while (!s_tready);
        tilt_q.push_back(r.known ? r.want : t);
        n_vec++;
        if (t.valid)
            n_valid++;
        else
            n_invalid++;
    endtask

    task automatic idle_gap(int n);
        s_tvalid <= 1'b0;
        repeat (n)
            @(posedge clk);
    endtask

    task automatic drain_and_write(logic [11:0] v);
        idle_gap(1);
        while (tilt_q.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        min_norm_q = v;
    endtask

    always @(posedge clk)
    begin
        tilt_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.roll = m_tdata[14:0];
            got.pitch = m_tdata[29:15];
            got.valid = m_tuser;
            if (tilt_q.size() == 0)
            begin
                $display("%0t unexpected result %h", $time, got);
                n_fail++;
            end
            else
            begin
                want = tilt_q.pop_front();
                if (got.roll !== want.roll)
                begin
                    $display("%0t roll exp %0d got %0d", $time, want.roll, got.roll);
                    n_fail++;
                end
                if (got.pitch !== want.pitch)
                begin
                    $display("%0t pitch exp %0d got %0d", $time, want.pitch, got.pitch);
                    n_fail++;
                end
                if (got.valid !== want.valid)
                begin
                    $display("%0t valid exp %0b got %0b", $time, want.valid, got.valid);
                    n_fail++;
                end
                if (m_tdata[31:30] !== 2'b00)
                begin
                    $display("%0t pad exp 0 got %b", $time, m_tdata[31:30]);
                    n_fail++;
                end
            end
        end
    end

    // receiver: alternates between free-running and random stalls
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= ~stall_mode;
        if (!stall_mode)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 3) != 0) && ($urandom_range(0, 40) != 0 || 1'b0);
    end

    function automatic vec_row_t mk(int x, int y, int z, bit k, int r, int p, bit v);
        vec_row_t row;
        row.x = 16'(x);
        row.y = 16'(y);
        row.z = 16'(z);
        row.known = k;
        row.want.roll = 15'(r);
        row.want.pitch = 15'(p);
        row.want.valid = v;
        return row;
    endfunction

    function automatic logic signed [15:0] rnd_comp();
        unique case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 20)) - 16'sd10;
            1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            2: return 16'($urandom_range(0, 2000)) - 16'sd1000;
            default: return 16'($urandom());
        endcase
    endfunction

    initial
    begin
        vec_row_t dir[$];
        vec_row_t r;
        logic [11:0] norms[6];
        int burst;
        norms = '{12'd0, 12'd4095, 12'd1, 12'd981, 12'd2000, 12'd10};
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir.push_back(mk(0, 0, 0, 1, 0, 0, 0));
        dir.push_back(mk(3, 4, 0, 1, 0, 0, 0));
        dir.push_back(mk(0, 0, 981, 1, 0, 0, 1));
        dir.push_back(mk(0, 0, -981, 1, 0, 0, 1));
        dir.push_back(mk(981, 0, 0, 1, 11520, 0, 1));
        dir.push_back(mk(-981, 0, 0, 1, -11520, 0, 1));
        dir.push_back(mk(0, 981, 0, 1, 0, 11520, 1));
        dir.push_back(mk(0, -32768, 0, 1, 0, -11520, 1));
        dir.push_back(mk(32767, 0, 0, 1, 11520, 0, 1));
        dir.push_back(mk(10, 0, 0, 1, 11520, 0, 1));
        dir.push_back(mk(9, 0, 0, 1, 0, 0, 0));
        dir.push_back(mk(-32768, -32768, -32768, 0, 0, 0, 0));
        dir.push_back(mk(32767, 32767, 32767, 0, 0, 0, 0));
        dir.push_back(mk(32767, -32768, 1, 0, 0, 0, 0));
        dir.push_back(mk(500, 500, 0, 0, 0, 0, 0));
        dir.push_back(mk(-700, 300, 600, 0, 0, 0, 0));
        dir.push_back(mk(1, 1, -1, 0, 0, 0, 0));
        dir.push_back(mk(-21846, 21845, -1, 0, 0, 0, 0));
        foreach (dir[i])
            send_vector(dir[i]);

        drain_and_write(12'd0);
        send_vector(mk(0, 0, 0, 1, 0, 0, 1));
        send_vector(mk(0, 1, 0, 1, 0, 11520, 1));

        for (int ph = 0; ph < 6; ph++)
        begin
            drain_and_write(norms[ph]);
            for (int n = 0; n < 146; n += burst)
            begin
                burst = $urandom_range(1, 24);
                for (int k = 0; k < burst; k++)
                begin
                    r.x = rnd_comp();
                    r.y = rnd_comp();
                    r.z = rnd_comp();
                    r.known = 0;
                    r.want = '0;
                    send_vector(r);
                end
                if ($urandom_range(0, 2) != 0)
                    idle_gap($urandom_range(1, 12));
            end
        end

        idle_gap(1);
        while (tilt_q.size() != 0)
            @(posedge clk);
        repeat (80)
            @(posedge clk);
        $display("Sent %0d gravity vectors (%0d valid, %0d below minimum) over 8 min_norm settings",
                 n_vec, n_valid, n_invalid);
        $display("with bursty input and stalled output.");
        if (n_fail == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
sv/gvt_pkg.sv
sv/gvt_front.sv
sv/gvt_sqrt.sv
sv/gvt_cordic.sv
sv/gravity_vector_to_tilt_unit.sv
sv/gvt_checker.sv
tb/sv/gravity_vector_to_tilt_unit_tb.sv
